@@ rtl/mexp_pkg.sv @@
// Shared operand width for the modular exponentiation unit.
package mexp_pkg;

  localparam int MEXP_OPERAND_BITS = 31;

endpackage

@@ rtl/mexp_mulmod.sv @@
// Bit-serial interleaved multiply-reduce: product = x * y mod m.
module mexp_mulmod
  import mexp_pkg::*;
#(
  parameter int OPERAND_BITS = MEXP_OPERAND_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [OPERAND_BITS-1:0] x,
  input  logic [OPERAND_BITS-1:0] y,
  input  logic [OPERAND_BITS-1:0] m,
  output logic                    done,
  output logic [OPERAND_BITS-1:0] product
);

  localparam int CNT_W = $clog2(OPERAND_BITS + 1);

  logic                    busy_r;
  logic                    done_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [OPERAND_BITS-1:0] acc_r;
  logic [OPERAND_BITS-1:0] acc_nxt;
  logic [OPERAND_BITS-1:0] y_r;
  logic [OPERAND_BITS:0]   dbl;
  logic [OPERAND_BITS:0]   dbl_red;
  logic [OPERAND_BITS:0]   sum;
  logic [OPERAND_BITS:0]   sum_red;
  logic [OPERAND_BITS:0]   m_ext;
  logic                    last_step;

  // Each cycle doubles the accumulator and adds x when the next bit of y, taken from the
  // top, is set; both steps keep the accumulator below m with one conditional subtraction.
  always_comb begin
    m_ext   = {1'b0, m};
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
    sum     = {1'b0, dbl_red[OPERAND_BITS-1:0]} + (y_r[OPERAND_BITS-1] ? {1'b0, x} : '0);
    sum_red = (sum >= m_ext) ? (sum - m_ext) : sum;
    acc_nxt = sum_red[OPERAND_BITS-1:0];
  end

  assign last_step = busy_r && (cnt_r == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= last_step;
      if (start) begin
        busy_r <= 1'b1;
      end else if (last_step) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      y_r   <= y;
      cnt_r <= CNT_W'(OPERAND_BITS);
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      y_r   <= {y_r[OPERAND_BITS-2:0], 1'b0};
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

@@ rtl/modular_exponentiation_unit.sv @@
// Modular exponentiation unit: right-to-left binary square-and-multiply.
//
// Input channel: in_base_value, in_exponent and in_modulus move in one transfer when
// in_valid is high and in_stall is low. The unit works on one item at a time and holds
// in_stall high from the cycle after a transfer until the item's result has been placed
// in the output register.
// Result channel: out_residue is held in an output register with out_valid; the receiver
// holds out_stall high to keep it there. A new item may be taken while a result waits.
// Every modular product goes through one bit-serial multiply-reduce unit. An item is
// taken and its base reduced, then for each exponent bit up to the highest set bit the
// unit runs a step, a multiply when that bit is set, and a square; it then finishes by
// loading the result into the output register.
// If the output register is still full when a result is ready, the unit waits until the
// receiver takes it. Reset empties the output register and returns the unit to idle.
module modular_exponentiation_unit
  import mexp_pkg::*;
#(
  parameter int OPERAND_BITS = MEXP_OPERAND_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OPERAND_BITS-1:0] in_base_value,
  input  logic [OPERAND_BITS-1:0] in_exponent,
  input  logic [OPERAND_BITS-1:0] in_modulus,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [OPERAND_BITS-1:0] out_residue
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_REDUCE = 6'b000010,
    S_STEP   = 6'b000100,
    S_MUL    = 6'b001000,
    S_SQR    = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t                  state_r;
  state_t                  state_nxt;
  logic                    start_r;
  logic                    start_nxt;
  logic                    out_valid_r;
  logic [OPERAND_BITS-1:0] res_r;
  logic [OPERAND_BITS-1:0] acc_r;
  logic [OPERAND_BITS-1:0] pw_r;
  logic [OPERAND_BITS-1:0] exp_r;
  logic [OPERAND_BITS-1:0] mod_r;
  logic [OPERAND_BITS-1:0] mm_x;
  logic [OPERAND_BITS-1:0] mm_product;
  logic                    mm_done;
  logic                    in_xfer;
  logic                    out_xfer;
  logic                    load_out;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign load_out = (state_r == S_FINISH) && (!out_valid_r || !out_stall);

  // The base is reduced as 1 * base mod m, so the multiplier needs no separate divider.
  always_comb begin
    unique case (state_r)
      S_MUL:   mm_x = acc_r;
      S_SQR:   mm_x = pw_r;
      default: mm_x = OPERAND_BITS'(1);
    endcase
  end

  mexp_mulmod #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_mulmod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start_r),
    .x      (mm_x),
    .y      (pw_r),
    .m      (mod_r),
    .done   (mm_done),
    .product(mm_product)
  );

  always_comb begin
    state_nxt = state_r;
    start_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_REDUCE;
          start_nxt = 1'b1;
        end
      end
      S_REDUCE: begin
        if (mm_done) begin
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        priority if (exp_r == '0) begin
          state_nxt = S_FINISH;
        end else if (exp_r[0]) begin
          state_nxt = S_MUL;
          start_nxt = 1'b1;
        end else begin
          state_nxt = S_SQR;
          start_nxt = 1'b1;
        end
      end
      S_MUL: begin
        if (mm_done) begin
          state_nxt = S_SQR;
          start_nxt = 1'b1;
        end
      end
      S_SQR: begin
        if (mm_done) begin
          state_nxt = S_STEP;
        end
      end
      S_FINISH: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= start_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // A zero modulus clears the exponent so that the result stays at zero.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pw_r  <= in_base_value;
      mod_r <= in_modulus;
      acc_r <= OPERAND_BITS'(in_modulus > OPERAND_BITS'(1));
      exp_r <= (in_modulus == '0) ? '0 : in_exponent;
    end else begin
      if (mm_done && (state_r == S_REDUCE || state_r == S_SQR)) begin
        pw_r <= mm_product;
      end
      if (mm_done && state_r == S_MUL) begin
        acc_r <= mm_product;
      end
      if (mm_done && state_r == S_SQR) begin
        exp_r <= {1'b0, exp_r[OPERAND_BITS-1:1]};
      end
    end
    if (load_out) begin
      res_r <= acc_r;
    end
  end

  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_residue = res_r;

endmodule

@@ rtl/mexp_checker.sv @@
// Port-level checks for the modular exponentiation unit, bound to the top level.
module mexp_checker
  import mexp_pkg::*;
#(
  parameter int OPERAND_BITS = MEXP_OPERAND_BITS
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [OPERAND_BITS-1:0] out_residue
);

  // After reset the output register is empty.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending straight after reset");

  // The unit works on one item at a time, so it must stall after taking one.
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again while an item is in progress");

  // A result only appears after an item has been in progress.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_residue)))
    else $error("stalled result changed");

endmodule

bind modular_exponentiation_unit mexp_checker #(
  .OPERAND_BITS(OPERAND_BITS)
) u_mexp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_residue(out_residue)
);
